/* rtl/core/hafc_pkg.sv */
// hafc_pkg: shared types, constants and the CRC-16/X.25 byte update for the
// async HDLC framer. No dependencies.
package hafc_pkg;

    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // item kind on the input tuser bit
    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_RX = 1'b1;

    // result direction on output tuser bit 0
    localparam logic DIR_LINE    = 1'b0;
    localparam logic DIR_PAYLOAD = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 4;

    // one queued job: a tx byte (with optional FCS + flag) or one rx result
    typedef struct packed {
        logic        rx;    // KIND_RX: single receive result
        logic        last;  // tx: append FCS and flag; rx: bare frame-end marker
        logic [7:0]  data;
        logic [15:0] fcs;   // tx only, already inverted
    } job_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_FLAG
    } phase_t;

    // reflected CRC-16, one byte, eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

endpackage

/* rtl/core/hafc_front.sv */
// hafc_front: accepts input transfers, runs the tx CRC and the rx unescape /
// two-byte hold, and issues jobs to the queue. Depends on hafc_pkg.
module hafc_front import hafc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,     // input transfer this cycle
    input  logic       in_kind,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output job_t       push_job
);

    logic [15:0] tx_crc_reg, tx_crc_next;
    logic        esc_pend_reg, esc_pend_next;
    logic [7:0]  hold0_reg, hold0_next;
    logic [7:0]  hold1_reg, hold1_next;
    logic [1:0]  hold_cnt_reg, hold_cnt_next;

    logic [15:0] crc_upd;
    logic [7:0]  rx_val;
    logic        rx_is_data;

    always_comb begin
        crc_upd       = crc16_byte(tx_crc_reg, in_byte);
        tx_crc_next   = tx_crc_reg;
        esc_pend_next = esc_pend_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        hold_cnt_next = hold_cnt_reg;
        rx_val        = in_byte;
        rx_is_data    = 1'b0;
        push          = 1'b0;
        push_job      = '{rx: in_kind, last: in_last, data: in_byte, fcs: ~crc_upd};

        if (accept) begin
            if (in_kind == KIND_TX) begin
                push        = 1'b1;
                tx_crc_next = in_last ? CRC_INIT : crc_upd;
            end else begin
                push_job.last = 1'b0;
                if (esc_pend_reg) begin
                    esc_pend_next = 1'b0;
                    rx_val        = in_byte ^ ESC_XOR;
                    rx_is_data    = 1'b1;
                end else if (in_byte == FLAG_BYTE) begin
                    hold_cnt_next = 2'd0;
                    hold0_next    = 8'h00;
                    hold1_next    = 8'h00;
                    push          = 1'b1;
                    push_job.last = 1'b1;
                    push_job.data = 8'h00;
                end else if (in_byte == ESC_BYTE) begin
                    esc_pend_next = 1'b1;
                end else begin
                    rx_is_data = 1'b1;
                end

                if (rx_is_data) begin
                    if (hold_cnt_reg[1]) begin
                        push          = 1'b1;
                        push_job.data = hold0_reg;
                        hold0_next    = hold1_reg;
                        hold1_next    = rx_val;
                    end else if (hold_cnt_reg == 2'd0) begin
                        hold0_next    = rx_val;
                        hold_cnt_next = 2'd1;
                    end else begin
                        hold1_next    = rx_val;
                        hold_cnt_next = 2'd2;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_crc_reg   <= CRC_INIT;
            esc_pend_reg <= 1'b0;
            hold0_reg    <= 8'h00;
            hold1_reg    <= 8'h00;
            hold_cnt_reg <= 2'd0;
        end else begin
            tx_crc_reg   <= tx_crc_next;
            esc_pend_reg <= esc_pend_next;
            hold0_reg    <= hold0_next;
            hold1_reg    <= hold1_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

endmodule

/* rtl/core/hafc_fifo.sv */
// hafc_fifo: small register queue between front and back end.
// Generic width and depth; no package dependencies.
module hafc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/hafc_back.sv */
// hafc_back: expands queued jobs into result transfers (escaping, FCS, flag)
// and holds the output register. Depends on hafc_pkg.
module hafc_back import hafc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    input  job_t       job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [2:0] m_tuser,
    output logic       m_tlast
);

    phase_t     phase_reg, phase_next;
    logic       esc2_reg, esc2_next;       // second half of an escape pair
    logic       vld_reg, vld_next;
    logic [7:0] data_reg, data_next;
    logic [2:0] user_reg, user_next;       // {frame_end, carries_data, direction}
    logic       last_reg, last_next;

    logic       load;
    logic [7:0] cur;

    assign load = !vld_reg || m_tready;

    always_comb begin
        phase_next = phase_reg;
        esc2_next  = esc2_reg;
        vld_next   = vld_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        case (phase_reg)
            PH_DATA:   cur = job.data;
            PH_FCS_LO: cur = job.fcs[7:0];
            PH_FCS_HI: cur = job.fcs[15:8];
            PH_FLAG:   cur = FLAG_BYTE;
            default:   cur = job.data;
        endcase

        if (job_valid && load) begin
            vld_next = 1'b1;
            if (job.rx == KIND_RX) begin
                data_next = job.data;
                user_next = {job.last, !job.last, DIR_PAYLOAD};
                last_next = 1'b1;
                pop       = 1'b1;
            end else if (phase_reg == PH_FLAG) begin
                data_next  = FLAG_BYTE;
                user_next  = {1'b1, 1'b1, DIR_LINE};
                last_next  = 1'b1;
                pop        = 1'b1;
                phase_next = PH_DATA;
            end else if (needs_escape(cur) && !esc2_reg) begin
                data_next = ESC_BYTE;
                user_next = {1'b0, 1'b1, DIR_LINE};
                last_next = 1'b0;
                esc2_next = 1'b1;
            end else begin
                data_next = esc2_reg ? (cur ^ ESC_XOR) : cur;
                user_next = {1'b0, 1'b1, DIR_LINE};
                esc2_next = 1'b0;
                last_next = 1'b0;
                case (phase_reg)
                    PH_DATA: begin
                        if (job.last) begin
                            phase_next = PH_FCS_LO;
                        end else begin
                            last_next = 1'b1;
                            pop       = 1'b1;
                        end
                    end
                    PH_FCS_LO: phase_next = PH_FCS_HI;
                    PH_FCS_HI: phase_next = PH_FLAG;
                    default:   phase_next = PH_DATA;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
            esc2_reg  <= 1'b0;
            vld_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            esc2_reg  <= esc2_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/hafc_back_dummy_never.sv */
// hafc_back_dummy_never: port-level sanity checks on the result stream of the
// framer. Depends on hafc_pkg.
module hafc_back_dummy_never import hafc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // bare receive marker is always the only result of its item and carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == DIR_PAYLOAD && !m_tuser[1])
            |-> (m_tdata == 8'h00 && m_tuser[2] && m_tlast))
        else $error("rx marker malformed");

endmodule

/* rtl/core/hdlc_async_framer_crc16_unit.sv */
// hdlc_async_framer_crc16_unit: async HDLC framer/deframer with CRC-16/X.25.
// Depends on hafc_pkg, hafc_front, hafc_fifo, hafc_back, hafc_back_dummy_never.
//
// One stream carries both directions: s_tuser selects a transmit payload byte
// or a received line byte. The front end takes one input transfer per cycle
// whenever the job queue (QUEUE_DEPTH entries) has room, updates the CRC or the
// receive unescape/hold state in that cycle, and queues at most one job. The
// back end drains one job at a time and emits one result transfer per cycle
// while m_tready does not stall it: a transmit byte gives one or two line
// bytes, and with s_tlast also the escaped inverted CRC (low byte first) and
// a closing 0x7E, up to seven results; a receive byte gives zero or one
// result. Results are paced by the back-end sequencer; input transfers
// overlap with output through the queue and the output register. Received
// bytes lag by two: the two bytes held at a flag are the FCS and are dropped
// unchecked, and the flag produces a bare frame-end marker.
// m_tlast marks the last result of each input item.
module hdlc_async_framer_crc16_unit import hafc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] kind (0 transmit, 1 receive)
    input  logic       s_tlast,   // end_of_payload
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] direction, [1] carries_data, [2] frame_end
    output logic       m_tlast    // run_last
);

    logic  accept;
    logic  push, pop, full, empty;
    job_t  push_job, head_job;
    logic [$bits(job_t)-1:0] head_bits;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    hafc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_job (push_job)
    );

    hafc_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (head_bits),
        .full      (full),
        .empty     (empty)
    );

    assign head_job = job_t'(head_bits);

    hafc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!empty),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    hafc_back_dummy_never u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // the queue never takes a job while full, and never pops while empty
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("pop from empty queue");

    // a sent frame end is the closing flag and ends its item's results
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == DIR_LINE && m_tuser[2])
            |-> (m_tdata == FLAG_BYTE && m_tlast))
        else $error("closing flag malformed");

    // an escape byte on the line is always followed by its escaped half,
    // so it never ends an item's results
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser[0] == DIR_LINE && m_tdata == ESC_BYTE)
            |-> !m_tlast)
        else $error("escape byte ended an item");

endmodule
